// File: hdl/map_tile_fifo_cache_lookup_top_macros.svh
// Assertion macros used by the tile cache lookup RTL.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef MAP_TILE_FIFO_CACHE_LOOKUP_TOP_MACROS_SVH
`define MAP_TILE_FIFO_CACHE_LOOKUP_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTFC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define MTFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle property failed");

`endif

// File: hdl/mtfc_pkg.sv
package mtfc_pkg;

    // Corner order within one view box.
    localparam logic [1:0] CORNER_MIN         = 2'd0;
    localparam logic [1:0] CORNER_MAX         = 2'd1;
    localparam logic [1:0] CORNER_MIN_X_MAX_Y = 2'd2;
    localparam logic [1:0] CORNER_MAX_X_MIN_Y = 2'd3;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
    } box_t;

    typedef struct packed {
        logic        [1:0]  corner;
        logic signed [31:0] tile_x;
        logic signed [31:0] tile_y;
        logic               hit;
        logic        [3:0]  slot;
        logic               evicted;
        logic        [3:0]  file_x;
        logic        [3:0]  file_y;
        logic signed [15:0] folder_x;
        logic signed [15:0] folder_y;
        logic        [15:0] view_mask;
        logic               last;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

endpackage

// File: hdl/mtfc_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module mtfc_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/map_tile_fifo_cache_lookup_top.sv
// Tile cache lookup for one map view box.
//
// The box channel (box_valid, box_stall, box) carries one view box, given as
// signed minimum and maximum corners. The result channel (res_valid,
// res_stall, res) returns exactly four transfers per box, one per corner in
// the order min, max, (min_x,max_y), (max_x,min_y); the fourth has last set
// and carries the in-view mask of all slots.
//
// Each corner is aligned down to its tile and searched in a fully associative
// tag store by one shared comparator, one stored entry per cycle, reading the
// single read port of the tag RAM. Only filled slots are searched. A corner
// resolves on the first hit or once every filled slot has been compared, and
// then posts its result, so early hits cut a box short. The box channel
// stalls from acceptance until the fourth result is posted.
//
// Reset empties the store: no slot is valid and the replacement pointer is at
// slot zero; the tag RAM itself is not cleared. A stall on the result channel
// holds the posted result; the next corner's search goes on meanwhile and
// waits to post until the output register is free.
module map_tile_fifo_cache_lookup_top #(
    parameter int SLOTS       = 16,
    parameter int TILE_BITS   = 12,
    parameter int FOLDER_BITS = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             box_valid,
    output logic             box_stall,
    input  mtfc_pkg::box_t   box,
    output logic             res_valid,
    input  logic             res_stall,
    output mtfc_pkg::result_t res
);

    `include "map_tile_fifo_cache_lookup_top_macros.svh"

    // Stored tag is the tile coordinate without its low TILE_BITS bits.
    localparam int TW         = 32 - TILE_BITS;
    localparam int AW         = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW         = $clog2(SLOTS + 1);
    localparam int FOLD_SHIFT = TILE_BITS + FOLDER_BITS;
    localparam logic [3:0] FILE_MASK = 4'((64'd1 << FOLDER_BITS) - 64'd1);

    mtfc_pkg::state_t  state_reg, state_next;
    mtfc_pkg::box_t    box_reg, box_next;
    logic [1:0]        corner_reg, corner_next;
    logic [CW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_idx_reg, pend_idx_next;
    logic              hit_reg, hit_next;
    logic [AW-1:0]     slot_reg, slot_next;
    logic              evict_reg, evict_next;
    logic [CW-1:0]     filled_reg, filled_next;
    logic [AW-1:0]     oldest_reg, oldest_next;
    logic [SLOTS-1:0]  view_reg, view_next;
    logic              res_valid_reg, res_valid_next;
    mtfc_pkg::result_t res_reg, res_next;

    logic signed [31:0] cur_x, cur_y;
    logic signed [31:0] tile_x, tile_y;
    logic signed [31:0] fold_x, fold_y;
    logic [2*TW-1:0]    cur_tag;
    logic [2*TW-1:0]    rd_data;
    logic               rd_en, wr_en;
    logic               full;
    logic               out_free;
    logic               match;
    logic [AW+3:0]      slot_ext;
    logic [SLOTS+15:0]  mask_ext;

    // Corner selection and tile alignment for the corner being worked on.
    always_comb
    begin
        cur_x = ((corner_reg == mtfc_pkg::CORNER_MIN) ||
                 (corner_reg == mtfc_pkg::CORNER_MIN_X_MAX_Y)) ? box_reg.min_x : box_reg.max_x;
        cur_y = ((corner_reg == mtfc_pkg::CORNER_MIN) ||
                 (corner_reg == mtfc_pkg::CORNER_MAX_X_MIN_Y)) ? box_reg.min_y : box_reg.max_y;
        tile_x  = {cur_x[31:TILE_BITS], {TILE_BITS{1'b0}}};
        tile_y  = {cur_y[31:TILE_BITS], {TILE_BITS{1'b0}}};
        cur_tag = {cur_x[31:TILE_BITS], cur_y[31:TILE_BITS]};
        fold_x  = tile_x >>> FOLD_SHIFT;
        fold_y  = tile_y >>> FOLD_SHIFT;
    end

    assign full      = (filled_reg == CW'(SLOTS));
    assign out_free  = !res_valid_reg || !res_stall;
    assign match     = pend_reg && (rd_data == cur_tag);
    assign box_stall = (state_reg != mtfc_pkg::ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        box_next       = box_reg;
        corner_next    = corner_reg;
        rd_ptr_next    = rd_ptr_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        evict_next     = evict_reg;
        filled_next    = filled_reg;
        oldest_next    = oldest_reg;
        view_next      = view_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        slot_ext       = {4'b0000, slot_reg};
        mask_ext       = '0;

        case (state_reg)
            mtfc_pkg::ST_IDLE:
            begin
                if (box_valid)
                begin
                    box_next    = box;
                    corner_next = mtfc_pkg::CORNER_MIN;
                    rd_ptr_next = '0;
                    pend_next   = 1'b0;
                    view_next   = '0;
                    state_next  = mtfc_pkg::ST_SEARCH;
                end
            end
            mtfc_pkg::ST_SEARCH:
            begin
                if (match)
                begin
                    hit_next   = 1'b1;
                    slot_next  = pend_idx_reg;
                    evict_next = 1'b0;
                    pend_next  = 1'b0;
                    state_next = mtfc_pkg::ST_FINISH;
                end
                else if (!pend_reg && (rd_ptr_reg >= filled_reg))
                begin
                    // Every filled slot compared without a match.
                    hit_next   = 1'b0;
                    slot_next  = full ? oldest_reg : filled_reg[AW-1:0];
                    evict_next = full;
                    state_next = mtfc_pkg::ST_FINISH;
                end
                else
                begin
                    rd_en         = (rd_ptr_reg < filled_reg);
                    pend_next     = rd_en;
                    pend_idx_next = rd_ptr_reg[AW-1:0];
                    if (rd_en)
                    begin
                        rd_ptr_next = rd_ptr_reg + CW'(1);
                    end
                end
            end
            mtfc_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    view_next           = view_reg;
                    view_next[slot_reg] = 1'b1;
                    if (!hit_reg)
                    begin
                        wr_en = 1'b1;
                        if (full)
                        begin
                            oldest_next = (oldest_reg == AW'(SLOTS - 1)) ?
                                          '0 : oldest_reg + AW'(1);
                        end
                        else
                        begin
                            filled_next = filled_reg + CW'(1);
                        end
                    end
                    if (corner_reg == mtfc_pkg::CORNER_MAX_X_MIN_Y)
                    begin
                        mask_ext = {16'h0000, view_next};
                    end
                    res_valid_next     = 1'b1;
                    res_next.corner    = corner_reg;
                    res_next.tile_x    = tile_x;
                    res_next.tile_y    = tile_y;
                    res_next.hit       = hit_reg;
                    res_next.slot      = slot_ext[3:0];
                    res_next.evicted   = evict_reg;
                    res_next.file_x    = tile_x[TILE_BITS +: 4] & FILE_MASK;
                    res_next.file_y    = tile_y[TILE_BITS +: 4] & FILE_MASK;
                    res_next.folder_x  = fold_x[15:0];
                    res_next.folder_y  = fold_y[15:0];
                    res_next.view_mask = mask_ext[15:0];
                    res_next.last      = (corner_reg == mtfc_pkg::CORNER_MAX_X_MIN_Y);
                    if (corner_reg == mtfc_pkg::CORNER_MAX_X_MIN_Y)
                    begin
                        state_next = mtfc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        corner_next = corner_reg + 2'd1;
                        rd_ptr_next = '0;
                        pend_next   = 1'b0;
                        state_next  = mtfc_pkg::ST_SEARCH;
                    end
                end
            end
            default:
            begin
                state_next = mtfc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mtfc_pkg::ST_IDLE;
            pend_reg      <= 1'b0;
            filled_reg    <= '0;
            oldest_reg    <= '0;
            view_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            filled_reg    <= filled_next;
            oldest_reg    <= oldest_next;
            view_reg      <= view_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        box_reg      <= box_next;
        corner_reg   <= corner_next;
        rd_ptr_reg   <= rd_ptr_next;
        pend_idx_reg <= pend_idx_next;
        hit_reg      <= hit_next;
        slot_reg     <= slot_next;
        evict_reg    <= evict_next;
        res_reg      <= res_next;
    end

    // Tag store: x and y tags side by side in one word per slot.
    mtfc_ram #(
        .WIDTH (2 * TW),
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (cur_tag),
        .rd_en   (rd_en),
        .rd_addr (rd_ptr_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // The fill count never passes the number of slots.
    `MTFC_ASSERT_SAME(a_fill_bound, 1'b1, filled_reg <= CW'(SLOTS))
    // Replacement only starts once every slot has been filled.
    `MTFC_ASSERT_SAME(a_oldest_idle, filled_reg < CW'(SLOTS), oldest_reg == '0)
    // The last flag belongs to the fourth corner only.
    `MTFC_ASSERT_SAME(a_last_corner, res_valid && res.last,
                      res.corner == mtfc_pkg::CORNER_MAX_X_MIN_Y)
    // A posted miss on a full store always reports an eviction.
    `MTFC_ASSERT_NEXT(a_evict_full,
                      (state_reg == mtfc_pkg::ST_FINISH) && out_free && !hit_reg && full,
                      res_valid && res.evicted)

endmodule

// File: sim/mtfc_corner_checker.sv
`timescale 1ns / 100ps
module mtfc_corner_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              box_valid,
    input  logic              box_stall,
    input  mtfc_pkg::box_t    box,
    input  logic              res_valid,
    input  logic              res_stall,
    input  mtfc_pkg::result_t res,
    output int                mismatches,
    output int                outstanding
);

    localparam int SLOTS        = 16;
    localparam int TILE_BITS    = 12;
    localparam int FOLDER_BITS  = 4;
    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the tag store and its replacement state.
    logic [31:0]      tag_x [SLOTS];
    logic [31:0]      tag_y [SLOTS];
    logic [SLOTS-1:0] held;
    logic [SLOTS-1:0] in_view;
    int unsigned      oldest;
    int unsigned      filled;

    mtfc_pkg::result_t expected_corners [$];
    int                bad_count;
    int                result_index;

    function automatic logic [31:0] tile_floor(input logic [31:0] v);
        return v & ~((32'd1 << TILE_BITS) - 32'd1);
    endfunction

    // Looks up the four corners of one box and queues the four results.
    task automatic predict_box(input mtfc_pkg::box_t b);
        logic [31:0]        px;
        logic [31:0]        py;
        logic [31:0]        tx;
        logic [31:0]        ty;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        mtfc_pkg::result_t  r;
        int                 slot_idx;
        bit                 found;
        in_view = '0;
        for (int k = 0; k < 4; k++)
        begin
            r = '0;
            case (k)
                0:
                begin
                    r.corner = mtfc_pkg::CORNER_MIN;
                    px = b.min_x;
                    py = b.min_y;
                end
                1:
                begin
                    r.corner = mtfc_pkg::CORNER_MAX;
                    px = b.max_x;
                    py = b.max_y;
                end
                2:
                begin
                    r.corner = mtfc_pkg::CORNER_MIN_X_MAX_Y;
                    px = b.min_x;
                    py = b.max_y;
                end
                default:
                begin
                    r.corner = mtfc_pkg::CORNER_MAX_X_MIN_Y;
                    px = b.max_x;
                    py = b.min_y;
                end
            endcase
            tx = tile_floor(px);
            ty = tile_floor(py);
            found = 1'b0;
            slot_idx = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!found && held[i] && tag_x[i] == tx && tag_y[i] == ty)
                begin
                    found = 1'b1;
                    slot_idx = i;
                end
            end
            if (!found)
            begin
                if (filled >= SLOTS)
                begin
                    slot_idx = oldest;
                    r.evicted = held[slot_idx];
                    oldest = (oldest + 1) % SLOTS;
                end
                else
                begin
                    slot_idx = filled;
                    filled++;
                end
                tag_x[slot_idx] = tx;
                tag_y[slot_idx] = ty;
                held[slot_idx] = 1'b1;
            end
            in_view[slot_idx] = 1'b1;
            fx = $signed(tx) >>> (TILE_BITS + FOLDER_BITS);
            fy = $signed(ty) >>> (TILE_BITS + FOLDER_BITS);
            r.tile_x   = tx;
            r.tile_y   = ty;
            r.hit      = found;
            r.slot     = slot_idx[3:0];
            r.file_x   = tx[TILE_BITS +: 4];
            r.file_y   = ty[TILE_BITS +: 4];
            r.folder_x = fx[15:0];
            r.folder_y = fy[15:0];
            r.last     = (k == 3);
            if (k == 3)
                r.view_mask = in_view[15:0];
            expected_corners = {expected_corners, r};
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            bad_count++;
            if (bad_count <= REPORT_LIMIT)
                $display("result %0d: %s expected %h, got %h", result_index, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held         = '0;
            in_view      = '0;
            oldest       = 0;
            filled       = 0;
            bad_count    = 0;
            result_index = 0;
            expected_corners.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_corners.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= REPORT_LIMIT)
                        $display("result %0d: unexpected transfer %h", result_index, res);
                end
                else
                begin
                    mtfc_pkg::result_t want;
                    want = expected_corners.pop_front();
                    check_field("corner",    32'(res.corner),    32'(want.corner));
                    check_field("tile_x",    32'(res.tile_x),    32'(want.tile_x));
                    check_field("tile_y",    32'(res.tile_y),    32'(want.tile_y));
                    check_field("hit",       32'(res.hit),       32'(want.hit));
                    check_field("slot",      32'(res.slot),      32'(want.slot));
                    check_field("evicted",   32'(res.evicted),   32'(want.evicted));
                    check_field("file_x",    32'(res.file_x),    32'(want.file_x));
                    check_field("file_y",    32'(res.file_y),    32'(want.file_y));
                    check_field("folder_x",  32'(res.folder_x),  32'(want.folder_x));
                    check_field("folder_y",  32'(res.folder_y),  32'(want.folder_y));
                    check_field("view_mask", 32'(res.view_mask), 32'(want.view_mask));
                    check_field("last",      32'(res.last),      32'(want.last));
                end
                result_index++;
            end
            if (box_valid && !box_stall)
                predict_box(box);
            mismatches  <= bad_count;
            outstanding <= expected_corners.size();
        end
    end

endmodule

// File: sim/map_tile_fifo_cache_lookup_top_tb.sv
`timescale 1ns / 100ps
module map_tile_fifo_cache_lookup_top_tb;

    // The limit leaves a wide margin over a full-store search per box, with
    // receiver stalls and sender gaps on top of that.
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 100;
    localparam int          LONG_HOLD    = 300;
    localparam logic [31:0] TILE_SPAN    = 32'd4096;

    logic              clk;
    logic              rst_n;
    logic              box_valid;
    logic              box_stall;
    mtfc_pkg::box_t    box;
    logic              res_valid;
    logic              res_stall = 1'b0;
    mtfc_pkg::result_t res;

    int fail_count;
    int outstanding;

    // Load controls for the sender and receiver processes; stall_pct and hold_go pass between them.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_go       = 1'b0;
    bit hold_taken    = 1'b0;
    int hold_left     = 0;

    // Region of the tile grid that local random boxes currently fall in.
    int region = 0;

    int unsigned cycle_count = 0;

    map_tile_fifo_cache_lookup_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .box_valid (box_valid),
        .box_stall (box_stall),
        .box       (box),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // The checker sits beside the block, predicts every result from the
    // accepted boxes and counts mismatches for the verdict below.
    mtfc_corner_checker corner_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .box_valid   (box_valid),
        .box_stall   (box_stall),
        .box         (box),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res),
        .mismatches  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: a hung handshake must still end the run with a verdict.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("map_tile_fifo_cache_lookup_top regression: fail");
            $finish;
        end
    end

    // Receiver. Stalls at random at the rate of the current phase. When the
    // sender asks for it once, it holds off for a long fixed stretch so that
    // the block backs up and has to stall its box channel.
    always @(negedge clk)
    begin
        if (hold_go && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD;
            res_stall  <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic mtfc_pkg::box_t mk_box(input logic [31:0] min_x,
                                              input logic [31:0] min_y,
                                              input logic [31:0] max_x,
                                              input logic [31:0] max_y);
        mtfc_pkg::box_t b;
        b.min_x = min_x;
        b.min_y = min_y;
        b.max_x = max_x;
        b.max_y = max_y;
        return b;
    endfunction

    function automatic logic [31:0] tile_at(input int unsigned idx);
        return idx * TILE_SPAN;
    endfunction

    // Most random boxes are small and land on a 7 by 7 patch of tiles in one
    // of four regions, so the 16-slot store sees a steady mix of hits, fills
    // and FIFO evictions. The rest are fully random boxes and boxes built
    // from extreme coordinates, which toggle every input bit.
    function automatic mtfc_pkg::box_t random_box();
        logic [31:0] v [4];
        logic [31:0] base_x;
        logic [31:0] base_y;
        logic [31:0] lo_x;
        logic [31:0] lo_y;
        logic [31:0] hi_x;
        logic [31:0] hi_y;
        int unsigned ix;
        int unsigned iy;
        int          pick;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 8)
            region = $urandom_range(3);
        if (pick < 12)
            return mk_box($urandom, $urandom, $urandom, $urandom);
        if (pick < 22)
        begin
            for (int f = 0; f < 4; f++)
            begin
                case ($urandom_range(4))
                    0:       v[f] = 32'h8000_0000;
                    1:       v[f] = 32'h7FFF_FFFF;
                    2:       v[f] = 32'h0000_0000;
                    3:       v[f] = 32'hFFFF_FFFF;
                    default: v[f] = $urandom;
                endcase
            end
            return mk_box(v[0], v[1], v[2], v[3]);
        end
        case (region)
            0:
            begin
                base_x = 32'h0000_0000;
                base_y = 32'h0000_0000;
            end
            1:
            begin
                base_x = 32'h7FFF_A000;
                base_y = 32'h7FFF_A000;
            end
            2:
            begin
                base_x = 32'h8000_0000;
                base_y = 32'h8000_0000;
            end
            default:
            begin
                base_x = 32'hFFFE_C000;
                base_y = 32'h1234_5000;
            end
        endcase
        ix = $urandom_range(4);
        iy = $urandom_range(4);
        lo_x = base_x + ix * TILE_SPAN + $urandom_range(TILE_SPAN - 1);
        lo_y = base_y + iy * TILE_SPAN + $urandom_range(TILE_SPAN - 1);
        hi_x = base_x + (ix + $urandom_range(2)) * TILE_SPAN + $urandom_range(TILE_SPAN - 1);
        hi_y = base_y + (iy + $urandom_range(2)) * TILE_SPAN + $urandom_range(TILE_SPAN - 1);
        // A few boxes arrive with their corners swapped; the block must not
        // care and simply looks them up as given.
        if ($urandom_range(99) < 8)
            return mk_box(hi_x, hi_y, lo_x, lo_y);
        return mk_box(lo_x, lo_y, hi_x, hi_y);
    endfunction

    // Offers one box after a random number of idle cycles and returns at the
    // falling edge after its transfer. Valid stays high between back-to-back
    // boxes, and the payload is held while the block stalls.
    task automatic send_box(input mtfc_pkg::box_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            box_valid <= 1'b0;
            @(negedge clk);
        end
        box_valid <= 1'b1;
        box       <= b;
        do
            @(posedge clk);
        while (box_stall);
        @(negedge clk);
    endtask

    // Sender pause: nothing more is offered until every predicted result has
    // come back.
    task automatic wait_for_results();
        box_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_in, input int items,
                             input bit long_hold);
        send_idle_pct = idle_pct;
        stall_pct    <= stall_in;
        for (int n = 0; n < items; n++)
        begin
            if (long_hold && n == 6)
                hold_go <= 1'b1;
            send_box(random_box());
        end
        wait_for_results();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        box_valid = 1'b0;
        box       = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed boxes, in an order that fills the empty store to exactly
        // sixteen slots and then forces replacement.
        // A zero box: one fill, then three repeated tiles within the box.
        send_box(mk_box(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        // The most negative and most positive coordinates: extreme folders.
        send_box(mk_box(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        // Swapped corners with low bits set inside the tiles.
        send_box(mk_box(tile_at(3) + 32'hABC, tile_at(3) + 32'h123,
                        tile_at(1) + 32'hFFF, tile_at(2)));
        // Small negative values align down to tiles minus one and minus two.
        send_box(mk_box(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_EC78, 32'hFFFF_FFFF));
        send_box(mk_box(tile_at(5), tile_at(5), tile_at(6), tile_at(6)));
        // All four corners in one tile; this fill makes the store full.
        send_box(mk_box(tile_at(7), tile_at(7), tile_at(7) + 32'hFFF, tile_at(7) + 32'hFFF));
        // The first corner hits the oldest slot and the next miss evicts it
        // while it is in view, so it stays in view with its new tile.
        send_box(mk_box(32'h0000_0000, 32'h0000_0000, tile_at(8), tile_at(8)));
        send_box(mk_box(32'h0000_0000, 32'h0000_0000, tile_at(8), tile_at(8)));
        send_box(mk_box(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555));
        send_box(mk_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        // Corners on either side of a tile boundary.
        send_box(mk_box(32'h0000_0FFF, 32'h0000_1000, 32'h0000_1000, 32'h0000_0FFF));
        wait_for_results();

        // Random boxes under four load patterns. The first pattern runs
        // without gaps and includes the long receiver hold-off.
        run_phase(0, 0, 50, 1'b1);
        run_phase(65, 0, 50, 1'b0);
        run_phase(0, 65, 50, 1'b0);
        run_phase(8, 8, 50, 1'b0);

        stall_pct <= 0;
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("map_tile_fifo_cache_lookup_top regression: pass");
        else
            $display("map_tile_fifo_cache_lookup_top regression: fail");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/mtfc_pkg.sv
hdl/mtfc_ram.sv
hdl/map_tile_fifo_cache_lookup_top.sv
sim/mtfc_corner_checker.sv
sim/map_tile_fifo_cache_lookup_top_tb.sv
